/* rtl/core/vgra_pkg.sv */
// Shared constants, types and helpers of the video gamut and range analyzer.
// Depends on nothing; the analyzer core takes everything by scoped names.
package vgra_pkg;

    localparam int HIST_SCALE  = 2048;
    localparam int COUNT_WIDTH = 32;
    localparam int NBINS       = 3 * HIST_SCALE + 1;
    localparam int HIST_DEPTH  = 3 * NBINS;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int Q_W         = 24;
    localparam int NUM_STATS   = 23;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic signed [Q_W-1:0]  q_t;
    typedef logic signed [21:0]     coef_t;

    localparam q_t Q_ONE  = 24'sd1048576;
    localparam q_t Q_HALF = 24'sd524288;
    localparam q_t Q_MAX  = 24'sd8388607;
    localparam q_t Q_MIN  = -24'sd8388608;

    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_BIN    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_SAMPLE_RANGE = 2'd0;
    localparam logic [1:0] CFG_IS_YCBCR     = 2'd1;
    localparam logic [1:0] CFG_BIT_DEPTH    = 2'd2;
    localparam logic [1:0] CFG_PRIMARIES    = 2'd3;

    localparam logic [2:0] RANGE_FULL   = 3'd0;
    localparam logic [2:0] RANGE_STD    = 3'd1;
    localparam logic [2:0] RANGE_RESTR  = 3'd2;
    localparam logic [2:0] RANGE_SDI16  = 3'd3;
    localparam logic [2:0] RANGE_SDI    = 3'd4;

    localparam logic [2:0] NUM_PRIMARIES = 3'd5;

    // Inverse matrices in Q.20, rows R, G, B over columns Y, Cb, Cr.
    localparam coef_t INV_MAT [5][3][3] = '{
        '{'{22'sd1048576, 22'sd0, 22'sd0},
          '{22'sd0, 22'sd1048576, 22'sd0},
          '{22'sd0, 22'sd0, 22'sd1048576}},
        '{'{22'sd1048576, 22'sd0, 22'sd1651297},
          '{22'sd1048576, -22'sd196423, -22'sd490864},
          '{22'sd1048576, 22'sd1945738, 22'sd0}},
        '{'{22'sd1048576, 22'sd0, 22'sd1546230},
          '{22'sd1048576, -22'sd172546, -22'sd599107},
          '{22'sd1048576, 22'sd1972791, 22'sd0}},
        '{'{22'sd1048576, 22'sd0, 22'sd1616904},
          '{22'sd1048576, -22'sd221362, -22'sd535305},
          '{22'sd1048576, 22'sd1930848, 22'sd0}},
        '{'{22'sd1048576, 22'sd0, 22'sd1470104},
          '{22'sd1048576, -22'sd360853, -22'sd748826},
          '{22'sd1048576, 22'sd1858077, 22'sd0}}
    };

    function automatic count_t count_inc(input count_t c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [31:0] out32(input count_t c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

endpackage

/* rtl/core/video_gamut_range_analyzer_unit.sv */
// Top level of the video gamut and range analyzer: control sequencer,
// shared divider, matrix multiplier and the histogram memory.
// Depends on vgra_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: luma, cb, cr, bin_index; tuser: op
//  m_      | out | m_tvalid/m_tready  | tdata: stat_index, stat_value, hist r/g/b
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// One word at a time. Each sample goes through a 24-step restoring divider;
// on YCbCr input each RGB row then takes three multiply/accumulate pairs and
// a read-modify-write of the histogram memory, which has separate read and
// write ports. A report streams 23 words, one per cycle while m_tready is
// high; an in-range bin read takes three memory reads and one word. After
// reset a clearing pass sweeps all 18435 histogram entries with s_tready low.
// Stalls on m_ hold the current word; s_tready is high only in idle.
module video_gamut_range_analyzer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [15:0] luma, [31:16] cb, [47:32] cr, [60:48] bin_index
    input  logic [1:0]   s_tuser,   // [1:0] op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // [4:0] stat_index, [36:5] stat_value, [68:37] red,
                                    // [100:69] green, [132:101] blue
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_wdata
);

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_NORM  = 5'd2;
    localparam logic [4:0] ST_OVF   = 5'd3;
    localparam logic [4:0] ST_DIV   = 5'd4;
    localparam logic [4:0] ST_NDONE = 5'd5;
    localparam logic [4:0] ST_MUL   = 5'd6;
    localparam logic [4:0] ST_ACC   = 5'd7;
    localparam logic [4:0] ST_RND   = 5'd8;
    localparam logic [4:0] ST_BMUL  = 5'd9;
    localparam logic [4:0] ST_BADDR = 5'd10;
    localparam logic [4:0] ST_HRD   = 5'd11;
    localparam logic [4:0] ST_HUPD  = 5'd12;
    localparam logic [4:0] ST_REP   = 5'd13;
    localparam logic [4:0] ST_BRD   = 5'd14;
    localparam logic [4:0] ST_BWT   = 5'd15;
    localparam logic [4:0] ST_BOUT  = 5'd16;

    localparam int HA = vgra_pkg::HIST_AW;

    typedef struct packed {
        logic signed [20:0] n;
        logic [18:0]        d;
    } norm_t;

    // Numerator and divisor of the range normalization for one sample.
    function automatic norm_t norm_calc(input logic [15:0] x, input logic chroma,
                                        input logic [2:0] rng, input logic [4:0] depth);
        logic [4:0]  b;
        logic [18:0] s;
        logic [18:0] full;
        logic [18:0] half;
        logic signed [20:0] xs;
        norm_t r;
        b = (depth < 5'd8) ? 5'd8 : ((depth > 5'd16) ? 5'd16 : depth);
        s = 19'd1 << (b - 5'd8);
        full = 19'd1 << b;
        half = 19'd1 << (b - 5'd1);
        xs = $signed({5'b0, x});
        case (rng)
            vgra_pkg::RANGE_STD: begin
                if (chroma) begin
                    r.n = xs - 21'(s << 7);
                    r.d = 19'(s * 19'd224);
                end else begin
                    r.n = xs - 21'(s << 4);
                    r.d = 19'(s * 19'd219);
                end
            end
            vgra_pkg::RANGE_RESTR: begin
                r.d = full - (19'd1 << (b - 5'd7));
                r.n = xs - 21'(chroma ? half : s);
            end
            vgra_pkg::RANGE_SDI16: begin
                if (chroma) begin
                    r.n = 21'(x >> 4) - 21'd2048;
                    r.d = 19'd4048;
                end else begin
                    r.n = 21'(x >> 4) - 21'd16;
                    r.d = 19'd4060;
                end
            end
            vgra_pkg::RANGE_SDI: begin
                if (chroma) begin
                    r.n = (xs - 21'(half)) <<< 2;
                    r.d = 19'(s * 19'd1012);
                end else begin
                    r.n = (xs - 21'(s)) <<< 2;
                    r.d = 19'(s * 19'd1015);
                end
            end
            default: begin
                r.d = full - 19'd1;
                r.n = xs - 21'(chroma ? half : 19'd0);
            end
        endcase
        return r;
    endfunction

    // Divide by 2^20, rounding halves away from zero.
    function automatic logic signed [47:0] rnd20(input logic signed [47:0] v);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = (m + 48'(vgra_pkg::Q_HALF)) >> 20;
        return v[47] ? -$signed(m) : $signed(m);
    endfunction

    function automatic vgra_pkg::q_t sat_q(input logic signed [47:0] v);
        if (v > 48'sd8388607) begin
            return vgra_pkg::Q_MAX;
        end else if (v < -48'sd8388608) begin
            return vgra_pkg::Q_MIN;
        end
        return vgra_pkg::q_t'(v);
    endfunction

    // configuration
    logic [2:0] sample_range_reg;
    logic       is_ycbcr_reg;
    logic [4:0] bit_depth_reg;
    logic [2:0] primaries_reg;

    // control
    logic [4:0]    state_reg;
    logic [HA-1:0] clr_cnt_reg;
    logic [1:0]    comp_reg;
    logic [1:0]    row_reg;
    logic [1:0]    col_reg;
    logic [4:0]    step_reg;
    logic [4:0]    stat_idx_reg;
    logic          lo_any_reg;
    logic          hi_any_reg;

    // frame statistics
    logic [15:0]           min_reg [3];
    logic [15:0]           max_reg [3];
    vgra_pkg::count_t      yuv_low_reg [4];
    vgra_pkg::count_t      yuv_high_reg [4];
    vgra_pkg::count_t      rgb_low_reg [4];
    vgra_pkg::count_t      rgb_high_reg [4];
    vgra_pkg::count_t      any_out_reg;

    // datapath
    logic [15:0]        smp_reg [3];
    logic [12:0]        bin_idx_reg;
    logic [39:0]        rem_reg;
    logic [18:0]        den_reg;
    logic [41:0]        dsh_reg;
    logic [23:0]        q_reg;
    logic               neg_reg;
    logic               ovf_reg;
    vgra_pkg::q_t       yuv_reg [3];
    logic signed [45:0] prod_reg;
    logic signed [47:0] acc_reg;
    vgra_pkg::q_t       rgb_reg;
    logic signed [37:0] bprod_reg;
    logic [HA-1:0]      addr_reg;
    logic [31:0]        hist_reg [3];

    // histogram memory
    vgra_pkg::count_t hist_mem [vgra_pkg::HIST_DEPTH];
    vgra_pkg::count_t mem_rdata_reg;
    logic             mem_we;
    logic [HA-1:0]    mem_wa;
    vgra_pkg::count_t mem_wd;
    logic             mem_re;
    logic [HA-1:0]    mem_ra;

    // combinational
    norm_t              nd;
    logic [18:0]        n_abs;
    logic [39:0]        num;
    logic               div_ge;
    vgra_pkg::q_t       norm_val;
    logic               n_lo;
    logic               n_hi;
    logic               n_is_chroma;
    vgra_pkg::q_t       rgb_val;
    logic signed [47:0] bin_r;
    logic signed [47:0] bin_c;
    logic [HA-1:0]      hist_addr;
    logic [HA-1:0]      bin_addr;
    logic               acc_in;
    logic [31:0]        stat_val;
    logic [4:0]         stat_j;
    logic [2:0]         prim_sel;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_REP) || (state_reg == ST_BOUT);
    assign m_tlast  = (state_reg == ST_BOUT) ||
                      (stat_idx_reg == 5'(vgra_pkg::NUM_STATS - 1));
    assign prim_sel = (primaries_reg < vgra_pkg::NUM_PRIMARIES) ? primaries_reg : 3'd0;

    // Normalize: numerator scaled to Q.20 plus half the divisor for rounding.
    always_comb begin
        n_is_chroma = is_ycbcr_reg && (comp_reg != 2'd0);
        nd = norm_calc(smp_reg[comp_reg], n_is_chroma, sample_range_reg, bit_depth_reg);
        n_abs = nd.n[20] ? 19'(-nd.n) : 19'(nd.n);
        num = (40'(n_abs) << 20) + 40'(nd.d >> 1);
        div_ge = (42'(rem_reg) >= dsh_reg);
        if (ovf_reg) begin
            norm_val = neg_reg ? vgra_pkg::Q_MIN : vgra_pkg::Q_MAX;
        end else begin
            norm_val = sat_q(neg_reg ? -$signed(48'(q_reg)) : $signed(48'(q_reg)));
        end
        if (is_ycbcr_reg && comp_reg != 2'd0) begin
            n_lo = norm_val < -vgra_pkg::Q_HALF;
            n_hi = norm_val > vgra_pkg::Q_HALF;
        end else begin
            n_lo = norm_val < 0;
            n_hi = norm_val > vgra_pkg::Q_ONE;
        end
    end

    // RGB rounding, histogram bin and memory address.
    always_comb begin
        rgb_val = sat_q(rnd20(acc_reg));
        bin_r = rnd20(48'(bprod_reg));
        if (bin_r < $signed(48'(-vgra_pkg::HIST_SCALE))) begin
            bin_c = $signed(48'(-vgra_pkg::HIST_SCALE));
        end else if (bin_r > $signed(48'(2 * vgra_pkg::HIST_SCALE))) begin
            bin_c = $signed(48'(2 * vgra_pkg::HIST_SCALE));
        end else begin
            bin_c = bin_r;
        end
        hist_addr = HA'(row_reg) * HA'(vgra_pkg::NBINS) +
                    HA'(bin_c + 48'(vgra_pkg::HIST_SCALE));
        bin_addr  = HA'(comp_reg) * HA'(vgra_pkg::NBINS) + HA'(bin_idx_reg);
    end

    // Memory port control: clearing sweep, histogram update and bin reads.
    always_comb begin
        mem_we = (state_reg == ST_CLEAR) || (state_reg == ST_HUPD);
        mem_wa = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
        mem_wd = (state_reg == ST_CLEAR) ? '0 : vgra_pkg::count_inc(mem_rdata_reg);
        mem_re = (state_reg == ST_HRD) || (state_reg == ST_BRD);
        mem_ra = (state_reg == ST_HRD) ? addr_reg : bin_addr;
    end

    // The read of a bin is issued only after the previous write has landed,
    // so no forwarding path is needed.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rdata_reg <= hist_mem[mem_ra];
        end
    end

    // Report word select.
    always_comb begin
        stat_val = '0;
        stat_j = stat_idx_reg - 5'd6;
        if (stat_idx_reg < 5'd6) begin
            stat_val = stat_idx_reg[0] ? 32'(max_reg[stat_idx_reg[2:1]])
                                       : 32'(min_reg[stat_idx_reg[2:1]]);
        end else if (stat_idx_reg < 5'd14) begin
            stat_val = stat_j[0] ? vgra_pkg::out32(yuv_high_reg[stat_j[2:1]])
                                 : vgra_pkg::out32(yuv_low_reg[stat_j[2:1]]);
        end else if (stat_idx_reg < 5'd22) begin
            stat_j = stat_idx_reg - 5'd14;
            stat_val = stat_j[0] ? vgra_pkg::out32(rgb_high_reg[stat_j[2:1]])
                                 : vgra_pkg::out32(rgb_low_reg[stat_j[2:1]]);
        end else begin
            stat_val = vgra_pkg::out32(any_out_reg);
        end
    end

    always_comb begin
        if (state_reg == ST_BOUT) begin
            m_tdata = {3'b0, hist_reg[2], hist_reg[1], hist_reg[0], 32'b0, 5'b0};
        end else begin
            m_tdata = {3'b0, 96'b0, stat_val, stat_idx_reg};
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_range_reg <= vgra_pkg::RANGE_FULL;
            is_ycbcr_reg     <= 1'b1;
            bit_depth_reg    <= 5'd10;
            primaries_reg    <= 3'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vgra_pkg::CFG_SAMPLE_RANGE: sample_range_reg <= cfg_wdata[2:0];
                vgra_pkg::CFG_IS_YCBCR:     is_ycbcr_reg     <= cfg_wdata[0];
                vgra_pkg::CFG_BIT_DEPTH:    bit_depth_reg    <= cfg_wdata;
                vgra_pkg::CFG_PRIMARIES:    primaries_reg    <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer and frame statistics.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            comp_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            step_reg     <= '0;
            stat_idx_reg <= '0;
            lo_any_reg   <= 1'b0;
            hi_any_reg   <= 1'b0;
            any_out_reg  <= '0;
            for (int k = 0; k < 3; k++) begin
                min_reg[k] <= 16'hFFFF;
                max_reg[k] <= 16'h0000;
            end
            for (int k = 0; k < 4; k++) begin
                yuv_low_reg[k]  <= '0;
                yuv_high_reg[k] <= '0;
                rgb_low_reg[k]  <= '0;
                rgb_high_reg[k] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == HA'(vgra_pkg::HIST_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc_in) begin
                        comp_reg <= 2'd0;
                        case (s_tuser)
                            vgra_pkg::OP_PIXEL: begin
                                for (int k = 0; k < 3; k++) begin
                                    if (s_tdata[16*k +: 16] < min_reg[k]) begin
                                        min_reg[k] <= s_tdata[16*k +: 16];
                                    end
                                    if (s_tdata[16*k +: 16] > max_reg[k]) begin
                                        max_reg[k] <= s_tdata[16*k +: 16];
                                    end
                                end
                                lo_any_reg <= 1'b0;
                                hi_any_reg <= 1'b0;
                                state_reg  <= ST_NORM;
                            end
                            vgra_pkg::OP_REPORT: begin
                                stat_idx_reg <= 5'd0;
                                state_reg    <= ST_REP;
                            end
                            vgra_pkg::OP_BIN: begin
                                if (32'(s_tdata[60:48]) >= 32'(vgra_pkg::NBINS)) begin
                                    state_reg <= ST_BOUT;
                                end else begin
                                    state_reg <= ST_BRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_NORM: state_reg <= ST_OVF;
                ST_OVF: begin
                    step_reg  <= 5'd23;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == 5'd0) begin
                        state_reg <= ST_NDONE;
                    end
                end
                ST_NDONE: begin
                    if (!is_ycbcr_reg) begin
                        if (n_lo) rgb_low_reg[comp_reg] <=
                            vgra_pkg::count_inc(rgb_low_reg[comp_reg]);
                        if (n_hi) rgb_high_reg[comp_reg] <=
                            vgra_pkg::count_inc(rgb_high_reg[comp_reg]);
                    end else begin
                        if (n_lo) yuv_low_reg[comp_reg] <=
                            vgra_pkg::count_inc(yuv_low_reg[comp_reg]);
                        if (n_hi) yuv_high_reg[comp_reg] <=
                            vgra_pkg::count_inc(yuv_high_reg[comp_reg]);
                    end
                    if (comp_reg == 2'd2) begin
                        if (!is_ycbcr_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            if (lo_any_reg | n_lo) yuv_low_reg[3] <=
                                vgra_pkg::count_inc(yuv_low_reg[3]);
                            if (hi_any_reg | n_hi) yuv_high_reg[3] <=
                                vgra_pkg::count_inc(yuv_high_reg[3]);
                            // reuse the flags for the RGB excursions
                            lo_any_reg <= 1'b0;
                            hi_any_reg <= 1'b0;
                            row_reg    <= 2'd0;
                            col_reg    <= 2'd0;
                            state_reg  <= ST_MUL;
                        end
                    end else begin
                        lo_any_reg <= lo_any_reg | n_lo;
                        hi_any_reg <= hi_any_reg | n_hi;
                        comp_reg   <= comp_reg + 1'b1;
                        state_reg  <= ST_NORM;
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (col_reg == 2'd2) begin
                        col_reg   <= 2'd0;
                        state_reg <= ST_RND;
                    end else begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_RND: begin
                    if (rgb_val < 0) begin
                        rgb_low_reg[row_reg] <= vgra_pkg::count_inc(rgb_low_reg[row_reg]);
                        lo_any_reg <= 1'b1;
                    end
                    if (rgb_val > vgra_pkg::Q_ONE) begin
                        rgb_high_reg[row_reg] <= vgra_pkg::count_inc(rgb_high_reg[row_reg]);
                        hi_any_reg <= 1'b1;
                    end
                    state_reg <= ST_BMUL;
                end
                ST_BMUL:  state_reg <= ST_BADDR;
                ST_BADDR: state_reg <= ST_HRD;
                ST_HRD:   state_reg <= ST_HUPD;
                ST_HUPD: begin
                    if (row_reg == 2'd2) begin
                        if (lo_any_reg) rgb_low_reg[3] <= vgra_pkg::count_inc(rgb_low_reg[3]);
                        if (hi_any_reg) rgb_high_reg[3] <=
                            vgra_pkg::count_inc(rgb_high_reg[3]);
                        if (lo_any_reg && hi_any_reg) begin
                            any_out_reg <= vgra_pkg::count_inc(
                                vgra_pkg::count_inc(any_out_reg));
                        end else if (lo_any_reg || hi_any_reg) begin
                            any_out_reg <= vgra_pkg::count_inc(any_out_reg);
                        end
                        state_reg <= ST_IDLE;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_REP: begin
                    if (m_tready) begin
                        if (stat_idx_reg == 5'(vgra_pkg::NUM_STATS - 1)) begin
                            // drop the frame statistics once the last word is taken
                            for (int k = 0; k < 3; k++) begin
                                min_reg[k] <= 16'hFFFF;
                                max_reg[k] <= 16'h0000;
                            end
                            for (int k = 0; k < 4; k++) begin
                                yuv_low_reg[k]  <= '0;
                                yuv_high_reg[k] <= '0;
                                rgb_low_reg[k]  <= '0;
                                rgb_high_reg[k] <= '0;
                            end
                            any_out_reg  <= '0;
                            stat_idx_reg <= 5'd0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            stat_idx_reg <= stat_idx_reg + 1'b1;
                        end
                    end
                end
                ST_BRD: state_reg <= ST_BWT;
                ST_BWT: begin
                    if (comp_reg == 2'd2) begin
                        state_reg <= ST_BOUT;
                    end else begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= ST_BRD;
                    end
                end
                ST_BOUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (acc_in) begin
                    smp_reg[0]  <= s_tdata[15:0];
                    smp_reg[1]  <= s_tdata[31:16];
                    smp_reg[2]  <= s_tdata[47:32];
                    bin_idx_reg <= s_tdata[60:48];
                    for (int k = 0; k < 3; k++) begin
                        hist_reg[k] <= '0;
                    end
                end
            end
            ST_NORM: begin
                rem_reg <= num;
                den_reg <= nd.d;
                neg_reg <= nd.n[20];
            end
            ST_OVF: begin
                ovf_reg <= (44'(rem_reg) >= (44'(den_reg) << 24));
                dsh_reg <= 42'(den_reg) << 23;
                q_reg   <= '0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - dsh_reg[39:0];
                end
                q_reg   <= {q_reg[22:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
            end
            ST_NDONE: begin
                yuv_reg[comp_reg] <= norm_val;
                acc_reg <= '0;
            end
            ST_MUL: begin
                prod_reg <= 46'(vgra_pkg::INV_MAT[prim_sel][row_reg][col_reg]) *
                            46'(yuv_reg[col_reg]);
            end
            ST_ACC:   acc_reg   <= acc_reg + 48'(prod_reg);
            ST_RND:   rgb_reg   <= rgb_val;
            ST_BMUL:  bprod_reg <= 38'(rgb_reg) * 38'(vgra_pkg::HIST_SCALE);
            ST_BADDR: addr_reg  <= hist_addr;
            ST_HUPD:  acc_reg   <= '0;
            ST_BWT:   hist_reg[comp_reg] <= vgra_pkg::out32(mem_rdata_reg);
            default: ;
        endcase
    end

    // Input is never taken while a result word is pending.
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a result word is pending");

    // A closing word returns the block to idle.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result words continue after the closing word");

    // Report words advance the statistic index by one.
    a_rep_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1))
        else $error("report index did not advance");

endmodule

/* sim/testbench.sv */
// Self-checking testbench of video_gamut_range_analyzer_unit: predicts every
// report and histogram word and compares it with the m_ stream.
// Depends on vgra_pkg and the analyzer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE20 = 1048576;
    localparam longint QHI = 8388607;
    localparam longint QLO = -8388608;
    localparam int BINS = 3 * 2048 + 1;
    // cycles a pixel may still take after the last expected word has come
    localparam int SETTLE = 200;

    // inverse matrices in Q.20, row-major R, G, B over Y, Cb, Cr
    localparam int MAT [5][9] = '{
        '{1048576, 0, 0, 0, 1048576, 0, 0, 0, 1048576},
        '{1048576, 0, 1651297, 1048576, -196423, -490864, 1048576, 1945738, 0},
        '{1048576, 0, 1546230, 1048576, -172546, -599107, 1048576, 1972791, 0},
        '{1048576, 0, 1616904, 1048576, -221362, -535305, 1048576, 1930848, 0},
        '{1048576, 0, 1470104, 1048576, -360853, -748826, 1048576, 1858077, 0}
    };

    typedef struct packed {
        logic [4:0]  stat_index;
        logic [31:0] stat_value;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        last;
    } stat_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // [15:0] luma, [31:16] cb, [47:32] cr, [60:48] bin_index
    logic [1:0]   s_tuser;   // [1:0] op
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // [4:0] index, [36:5] value, [68:37] r, [100:69] g, [132:101] b
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [4:0]   cfg_wdata;

    video_gamut_range_analyzer_unit i_dut (.*);

    // predictor state
    logic [2:0]  range_mode;
    logic        ycbcr_in;
    logic [4:0]  depth;
    logic [2:0]  prim;
    logic [15:0] min_smp [3];
    logic [15:0] max_smp [3];
    logic [31:0] yuv_lo [4];
    logic [31:0] yuv_hi [4];
    logic [31:0] rgb_lo [4];
    logic [31:0] rgb_hi [4];
    logic [31:0] excursions;
    logic [31:0] hist_r [BINS];
    logic [31:0] hist_g [BINS];
    logic [31:0] hist_b [BINS];

    stat_word_t expected_words[$];
    int         hit_bins[$];
    int         errors;
    bit         no_idle;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clip_q(longint v);
        return v > QHI ? QHI : (v < QLO ? QLO : v);
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
        return (&c) ? c : c + 32'd1;
    endfunction

    function automatic longint to_q20(logic [15:0] v, bit chroma);
        int b;
        longint s, full, half, x, n, d;
        b = depth < 8 ? 8 : (depth > 16 ? 16 : int'(depth));
        s = longint'(1) << (b - 8);
        full = longint'(1) << b;
        half = longint'(1) << (b - 1);
        x = longint'(v);
        case (range_mode)
            vgra_pkg::RANGE_STD: begin
                if (chroma) begin n = x - 128 * s; d = 224 * s; end
                else begin n = x - 16 * s; d = 219 * s; end
            end
            vgra_pkg::RANGE_RESTR: begin
                d = full - (longint'(1) << (b - 7));
                n = x - (chroma ? half : s);
            end
            vgra_pkg::RANGE_SDI16: begin
                if (chroma) begin n = (x >> 4) - 2048; d = 4048; end
                else begin n = (x >> 4) - 16; d = 4060; end
            end
            vgra_pkg::RANGE_SDI: begin
                if (chroma) begin n = (x - half) * 4; d = 1012 * s; end
                else begin n = (x - s) * 4; d = 1015 * s; end
            end
            default: begin
                d = full - 1;
                n = x - (chroma ? half : 0);
            end
        endcase
        return clip_q(round_div(n * ONE20, d));
    endfunction

    task automatic clear_frame_stats();
        for (int k = 0; k < 3; k++) begin min_smp[k] = 16'hFFFF; max_smp[k] = '0; end
        for (int k = 0; k < 4; k++) begin
            yuv_lo[k] = '0; yuv_hi[k] = '0; rgb_lo[k] = '0; rgb_hi[k] = '0;
        end
        excursions = '0;
    endtask

    task automatic analyze_pixel(logic [15:0] smp [3]);
        longint yuv [3];
        longint rgb, acc, bin;
        int m;
        bit lo_any, hi_any;
        lo_any = 0;
        hi_any = 0;
        for (int k = 0; k < 3; k++) begin
            if (smp[k] < min_smp[k]) min_smp[k] = smp[k];
            if (smp[k] > max_smp[k]) max_smp[k] = smp[k];
        end
        if (!ycbcr_in) begin
            // RGB input: per-component excursions only
            for (int k = 0; k < 3; k++) begin
                rgb = to_q20(smp[k], 0);
                if (rgb < 0) rgb_lo[k] = bump(rgb_lo[k]);
                if (rgb > ONE20) rgb_hi[k] = bump(rgb_hi[k]);
            end
            return;
        end
        for (int k = 0; k < 3; k++) begin
            yuv[k] = to_q20(smp[k], k != 0);
            if (yuv[k] < (k ? -ONE20 / 2 : 0)) begin
                yuv_lo[k] = bump(yuv_lo[k]);
                lo_any = 1;
            end
            if (yuv[k] > (k ? ONE20 / 2 : ONE20)) begin
                yuv_hi[k] = bump(yuv_hi[k]);
                hi_any = 1;
            end
        end
        if (lo_any) yuv_lo[3] = bump(yuv_lo[3]);
        if (hi_any) yuv_hi[3] = bump(yuv_hi[3]);
        lo_any = 0;
        hi_any = 0;
        m = prim < 5 ? int'(prim) : 0;
        for (int k = 0; k < 3; k++) begin
            acc = longint'(MAT[m][3*k]) * yuv[0] + longint'(MAT[m][3*k+1]) * yuv[1]
                + longint'(MAT[m][3*k+2]) * yuv[2];
            rgb = clip_q(round_div(acc, ONE20));
            if (rgb < 0) begin rgb_lo[k] = bump(rgb_lo[k]); lo_any = 1; end
            if (rgb > ONE20) begin rgb_hi[k] = bump(rgb_hi[k]); hi_any = 1; end
            bin = round_div(rgb * 2048, ONE20);
            if (bin < -2048) bin = -2048;
            if (bin > 4096) bin = 4096;
            bin += 2048;
            case (k)
                0: hist_r[bin] = bump(hist_r[bin]);
                1: hist_g[bin] = bump(hist_g[bin]);
                default: hist_b[bin] = bump(hist_b[bin]);
            endcase
            hit_bins.push_back(int'(bin));
            if (hit_bins.size() > 64) void'(hit_bins.pop_front());
        end
        if (lo_any) begin rgb_lo[3] = bump(rgb_lo[3]); excursions = bump(excursions); end
        if (hi_any) begin rgb_hi[3] = bump(rgb_hi[3]); excursions = bump(excursions); end
    endtask

    // turn one accepted word into its expected results
    task automatic predict_word(logic [1:0] op, logic [15:0] smp [3], logic [12:0] idx);
        stat_word_t w;
        logic [31:0] v [23];
        if (op == vgra_pkg::OP_PIXEL) begin
            analyze_pixel(smp);
        end else if (op == vgra_pkg::OP_REPORT) begin
            for (int k = 0; k < 3; k++) begin
                v[2*k] = 32'(min_smp[k]);
                v[2*k+1] = 32'(max_smp[k]);
            end
            for (int k = 0; k < 4; k++) begin
                v[6+2*k] = yuv_lo[k]; v[7+2*k] = yuv_hi[k];
                v[14+2*k] = rgb_lo[k]; v[15+2*k] = rgb_hi[k];
            end
            v[22] = excursions;
            for (int k = 0; k < 23; k++) begin
                w = '0;
                w.stat_index = 5'(k);
                w.stat_value = v[k];
                w.last = (k == 22);
                expected_words.push_back(w);
            end
            clear_frame_stats();
        end else if (op == vgra_pkg::OP_BIN) begin
            w = '0;
            if (idx < BINS) begin
                w.red = hist_r[idx]; w.green = hist_g[idx]; w.blue = hist_b[idx];
            end
            w.last = 1'b1;
            expected_words.push_back(w);
        end
        // the unused op is dropped by the block
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(logic [1:0] op, logic [15:0] y, logic [15:0] cb,
                             logic [15:0] cr, logic [12:0] idx);
        int gap;
        logic [15:0] smp [3];
        gap = pick_gap();
        smp[0] = y; smp[1] = cb; smp[2] = cr;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, idx, cr, cb, y};
        do @(posedge aclk); while (!s_tready);
        predict_word(op, smp, idx);
    endtask

    // drop valid, wait out every expected word and any pixel still in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (idx)
            vgra_pkg::CFG_SAMPLE_RANGE: range_mode = val[2:0];
            vgra_pkg::CFG_IS_YCBCR:     ycbcr_in = val[0];
            vgra_pkg::CFG_BIT_DEPTH:    depth = val;
            default:                    prim = val[2:0];
        endcase
    endtask

    task automatic set_mode(logic [2:0] rng, logic ycc, logic [4:0] bd, logic [2:0] pr);
        drain();
        write_reg(vgra_pkg::CFG_SAMPLE_RANGE, {2'b00, rng});
        write_reg(vgra_pkg::CFG_IS_YCBCR, {4'b0000, ycc});
        write_reg(vgra_pkg::CFG_BIT_DEPTH, bd);
        write_reg(vgra_pkg::CFG_PRIMARIES, {2'b00, pr});
    endtask

    task automatic send_pixel(logic [15:0] y, logic [15:0] cb, logic [15:0] cr);
        send_word(vgra_pkg::OP_PIXEL, y, cb, cr, 13'($urandom));
    endtask

    task automatic send_bin(logic [12:0] idx);
        send_word(vgra_pkg::OP_BIN, 16'($urandom), 16'($urandom), 16'($urandom), idx);
    endtask

    function automatic logic [15:0] rand_sample();
        int b;
        b = depth < 8 ? 8 : (depth > 16 ? 16 : int'(depth));
        // mostly inside the coded range, the rest anywhere in 16 bits
        if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, (1 << b) - 1));
        return 16'($urandom);
    endfunction

    function automatic logic [12:0] rand_bin();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && hit_bins.size() > 0)
            return 13'(hit_bins[$urandom_range(0, hit_bins.size()-1)]);
        if (r < 9) return 13'($urandom_range(0, BINS - 1));
        return 13'($urandom);
    endfunction

    // extremes of every field, each op, bins past the end, dropped op
    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd512, 16'd512, 16'd512);
        send_pixel(16'd1023, 16'd0, 16'd1023);
        send_pixel(16'd64, 16'd1023, 16'd0);
        send_word(vgra_pkg::OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        send_word(vgra_pkg::OP_REPORT, 16'h0, 16'h0, 16'h0, 13'h0);
        send_bin(13'd0);
        send_bin(13'd2048);
        send_bin(13'd4096);
        send_bin(13'd6144);
        send_bin(13'd6145);
        send_bin(13'h1FFF);
        // unknown range and primaries, depth below and above the legal span
        set_mode(3'd7, 1'b1, 5'd0, 3'd7);
        send_pixel(16'h00FF, 16'h0000, 16'hFFFF);
        send_pixel(16'h5555, 16'hAAAA, 16'h8000);
        set_mode(3'd5, 1'b1, 5'd31, 3'd5);
        send_pixel(16'hFFFF, 16'h0000, 16'h8000);
        send_pixel(16'h0001, 16'hFFFE, 16'h7FFF);
        send_word(vgra_pkg::OP_REPORT, 16'h0, 16'h0, 16'h0, 13'h0);
        send_bin(13'd0);
        send_bin(13'd6144);
    endtask

    // one phase of random words under a given setting
    task automatic run_phase(int count, bit pause_midway);
        int r;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 72) send_pixel(rand_sample(), rand_sample(), rand_sample());
            else if (r < 80) send_word(vgra_pkg::OP_REPORT, 16'($urandom), 16'($urandom),
                                       16'($urandom), 13'($urandom));
            else if (r < 97) send_bin(rand_bin());
            else send_word(vgra_pkg::OP_UNUSED, 16'($urandom), 16'($urandom),
                           16'($urandom), 13'($urandom));
        end
        send_word(vgra_pkg::OP_REPORT, 16'h0, 16'h0, 16'h0, 13'h0);
    endtask

    task automatic test_range_modes();
        set_mode(vgra_pkg::RANGE_FULL, 1'b1, 5'd8, 3'd1);
        run_phase(45, 0);
        set_mode(vgra_pkg::RANGE_STD, 1'b1, 5'd10, 3'd2);
        run_phase(45, 0);
        set_mode(vgra_pkg::RANGE_RESTR, 1'b1, 5'd16, 3'd3);
        run_phase(45, 0);
        set_mode(vgra_pkg::RANGE_SDI16, 1'b1, 5'd16, 3'd4);
        run_phase(45, 0);
        set_mode(vgra_pkg::RANGE_SDI, 1'b1, 5'd12, 3'd0);
        run_phase(45, 0);
    endtask

    task automatic test_rgb_input();
        set_mode(vgra_pkg::RANGE_STD, 1'b0, 5'd8, 3'd1);
        run_phase(40, 0);
        set_mode(vgra_pkg::RANGE_SDI, 1'b0, 5'd16, 3'd2);
        run_phase(40, 0);
    endtask

    // no idling at all, then a pause in the sender until all words are back
    task automatic test_back_to_back();
        set_mode(vgra_pkg::RANGE_FULL, 1'b1, 5'd10, 3'd1);
        no_idle = 1;
        run_phase(40, 0);
        no_idle = 0;
        set_mode(vgra_pkg::RANGE_RESTR, 1'b1, 5'd8, 3'd4);
        run_phase(40, 1);
    endtask

    task automatic report_mismatch(string what, stat_word_t want, stat_word_t got);
        errors++;
        $display("mismatch %s: expected idx %0d val %h rgb %h/%h/%h last %b, ",
                 what, want.stat_index, want.stat_value, want.red, want.green, want.blue,
                 want.last, "got idx %0d val %h rgb %h/%h/%h last %b",
                 got.stat_index, got.stat_value, got.red, got.green, got.blue, got.last);
    endtask

    // result side: random stalls, check every accepted word
    int stall_left;
    always @(posedge aclk) begin
        stat_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.stat_index = m_tdata[4:0];
            got.stat_value = m_tdata[36:5];
            got.red        = m_tdata[68:37];
            got.green      = m_tdata[100:69];
            got.blue       = m_tdata[132:101];
            got.last       = m_tlast;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.stat_index != want.stat_index) report_mismatch("stat_index", want, got);
                if (got.stat_value != want.stat_value) report_mismatch("stat_value", want, got);
                if (got.red != want.red) report_mismatch("hist_red", want, got);
                if (got.green != want.green) report_mismatch("hist_green", want, got);
                if (got.blue != want.blue) report_mismatch("hist_blue", want, got);
                if (got.last != want.last) report_mismatch("last", want, got);
            end
        end
        // pick the next ready level: mostly ready, a few short or long stalls
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (no_idle || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                    : $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        stall_left = 0;
        errors     = 0;
        no_idle    = 0;
        range_mode = vgra_pkg::RANGE_FULL;
        ycbcr_in   = 1'b1;
        depth      = 5'd10;
        prim       = 3'd1;
        clear_frame_stats();
        for (int k = 0; k < BINS; k++) begin hist_r[k] = '0; hist_g[k] = '0; hist_b[k] = '0; end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // hold off until the histogram clearing pass is done
        do @(posedge aclk); while (!s_tready);

        test_directed();
        test_range_modes();
        test_rgb_input();
        test_back_to_back();

        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/vgra_pkg.sv
rtl/core/video_gamut_range_analyzer_unit.sv
sim/testbench.sv
